### rtl/ndef_uri_record_extractor_top_macros.svh
// assertion macros used by the port checker of the ndef uri record extractor
// depends on nothing; taken in by `include
`ifndef NDEF_URI_RECORD_EXTRACTOR_TOP_MACROS_SVH
`define NDEF_URI_RECORD_EXTRACTOR_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define NURX_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define NURX_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nurx_pkg.sv
// types, status codes and constants of the ndef uri record extractor
// no dependencies; used by the rtl modules through scoped names
`default_nettype none

package nurx_pkg;

  // input transaction payload
  typedef struct packed {
    logic [7:0]  in_byte;
    logic [16:0] buffer_length;
    logic        last_byte;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [7:0] url_byte;
    logic       has_byte;
    logic       final_res;
    logic [2:0] status;
    logic [7:0] url_length;
  } out_item_t;

  // result from the parse core for the current byte
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } nurx_res_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_LEN1  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_REC   = 3'd4,
    PH_URL   = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ARGS  = 3'd1;
  localparam logic [2:0] ST_NOT_TLV   = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_URL_BIG   = 3'd5;
  localparam logic [2:0] ST_NO_URI    = 3'd6;

  // byte constants
  localparam logic [7:0] NDEF_TLV_TAG = 8'h03;
  localparam logic [7:0] LONG_LEN_ESC = 8'hFF;
  localparam logic [7:0] TNF_MASK     = 8'h07;
  localparam logic [7:0] TNF_WELLKNOWN = 8'h01;
  localparam logic [7:0] URI_TYPE     = 8'h55;

  // register reset and index limit
  localparam logic [8:0]  URL_CAP_RESET = 9'd256;
  localparam logic [16:0] IDX_MAX       = 17'h1FFFF;

endpackage

`default_nettype wire

### rtl/nurx_in_stage.sv
// input register of the ndef uri record extractor
// depends on nurx_pkg
`default_nettype none

module nurx_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire nurx_pkg::in_item_t in_data,
  input  wire logic               take,
  output logic                    s1_valid,
  output nurx_pkg::in_item_t      s1_data
);

  // accept when empty or when the held byte moves on this cycle
  assign in_ready = !s1_valid || take;

  // held transaction valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // held payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

endmodule

`default_nettype wire

### rtl/nurx_parse_core.sv
// tlv / ndef record walker: parse state, url capacity register, per-byte result
// depends on nurx_pkg
`default_nettype none

module nurx_parse_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_wdata,
  input  wire logic               step,
  input  wire nurx_pkg::in_item_t item,
  output nurx_pkg::nurx_res_t     res
);

  logic [8:0]       url_capacity;
  nurx_pkg::phase_t phase, phase_next;
  logic [16:0]      byte_index, byte_index_next;
  logic [16:0]      held_buffer_length, held_buffer_length_next;
  logic [15:0]      message_length, message_length_next;
  logic [16:0]      message_end, message_end_next;
  logic [16:0]      record_start, record_start_next;
  logic [7:0]       record_header, record_header_next;
  logic [7:0]       record_type_length, record_type_length_next;
  logic [7:0]       record_payload_length, record_payload_length_next;
  logic [7:0]       url_bytes_left, url_bytes_left_next;
  logic [7:0]       url_count, url_count_next;

  logic [7:0]  b;
  logic [16:0] pos;
  logic [7:0]  pl_eff;
  logic [17:0] rec_end;
  logic [17:0] idx_plus1;
  logic [15:0] begin_ml;
  logic [16:0] begin_off;
  logic [16:0] begin_end;
  logic        cand;
  logic [7:0]  ulen;
  logic        verdict;
  logic [2:0]  verdict_st;
  logic        emit;
  logic        emit_final;

  // url capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      url_capacity <= nurx_pkg::URL_CAP_RESET;
    end else if (cfg_we) begin
      url_capacity <= cfg_wdata;
    end
  end

  // shared terms
  assign b         = item.in_byte;
  assign pos       = byte_index - record_start;
  assign pl_eff    = (pos == 17'd2) ? b : record_payload_length;
  assign rec_end   = {1'b0, record_start} + 18'd3 + {10'd0, record_type_length}
                     + {10'd0, pl_eff};
  assign idx_plus1 = {1'b0, byte_index} + 18'd1;
  assign begin_ml  = (phase == nurx_pkg::PH_LEN1) ? {8'd0, b} : {message_length[15:8], b};
  assign begin_off = (phase == nurx_pkg::PH_LEN1) ? 17'd2 : 17'd4;
  assign begin_end = begin_off + {1'b0, begin_ml};
  assign cand      = ((record_header & nurx_pkg::TNF_MASK) == nurx_pkg::TNF_WELLKNOWN)
                     && (record_type_length == 8'd1) && (record_payload_length >= 8'd2);
  assign ulen      = record_payload_length - 8'd1;

  // next state and result
  always_comb begin
    phase_next                 = phase;
    held_buffer_length_next    = held_buffer_length;
    message_length_next        = message_length;
    message_end_next           = message_end;
    record_start_next          = record_start;
    record_header_next         = record_header;
    record_type_length_next    = record_type_length;
    record_payload_length_next = record_payload_length;
    url_bytes_left_next        = url_bytes_left;
    url_count_next             = url_count;
    verdict                    = 1'b0;
    verdict_st                 = nurx_pkg::ST_OK;
    emit                       = 1'b0;
    emit_final                 = 1'b0;

    case (phase)
      nurx_pkg::PH_TAG: begin
        held_buffer_length_next = item.buffer_length;
        if (item.buffer_length < 17'd4 || url_capacity < 9'd2) begin
          verdict    = 1'b1;
          verdict_st = nurx_pkg::ST_BAD_ARGS;
        end else if (b != nurx_pkg::NDEF_TLV_TAG) begin
          verdict    = 1'b1;
          verdict_st = nurx_pkg::ST_NOT_TLV;
        end else begin
          phase_next = nurx_pkg::PH_LEN1;
        end
      end
      nurx_pkg::PH_LEN1, nurx_pkg::PH_LENLO: begin
        if (phase == nurx_pkg::PH_LEN1 && b == nurx_pkg::LONG_LEN_ESC) begin
          if (held_buffer_length < 17'd5) begin
            verdict    = 1'b1;
            verdict_st = nurx_pkg::ST_TOO_SHORT;
          end else begin
            phase_next = nurx_pkg::PH_LENHI;
          end
        end else begin
          // length complete: validate and start the record walk
          message_length_next = begin_ml;
          if (begin_ml == 16'd0 || begin_end > held_buffer_length) begin
            verdict    = 1'b1;
            verdict_st = nurx_pkg::ST_BAD_LEN;
          end else begin
            message_end_next  = begin_end;
            record_start_next = begin_off;
            if (begin_ml < 16'd3) begin
              verdict    = 1'b1;
              verdict_st = nurx_pkg::ST_NO_URI;
            end else begin
              phase_next = nurx_pkg::PH_REC;
            end
          end
        end
      end
      nurx_pkg::PH_LENHI: begin
        message_length_next = {b, 8'd0};
        phase_next          = nurx_pkg::PH_LENLO;
      end
      nurx_pkg::PH_REC: begin
        if (pos == 17'd0) begin
          record_header_next = b;
        end else if (pos == 17'd1) begin
          record_type_length_next = b;
        end else begin
          if (pos == 17'd2) begin
            record_payload_length_next = b;
          end
          if (pos == 17'd2 && rec_end > {1'b0, message_end}) begin
            verdict    = 1'b1;
            verdict_st = nurx_pkg::ST_NO_URI;
          end else if (pos == 17'd3 && cand && b == nurx_pkg::URI_TYPE) begin
            if ({1'b0, ulen} >= url_capacity) begin
              verdict    = 1'b1;
              verdict_st = nurx_pkg::ST_URL_BIG;
            end else begin
              phase_next          = nurx_pkg::PH_URL;
              url_bytes_left_next = ulen;
              url_count_next      = 8'd0;
            end
          end else if (idx_plus1 == rec_end) begin
            // step to the next record
            record_start_next = rec_end[16:0];
            if (({1'b0, message_end} - rec_end) < 18'd3) begin
              verdict    = 1'b1;
              verdict_st = nurx_pkg::ST_NO_URI;
            end
          end
        end
      end
      nurx_pkg::PH_URL: begin
        // the byte after the type is the prefix code and is skipped
        if (pos != 17'd4) begin
          emit                = 1'b1;
          url_count_next      = url_count + 8'd1;
          url_bytes_left_next = url_bytes_left - 8'd1;
          if (url_bytes_left == 8'd1) begin
            emit_final = 1'b1;
            phase_next = nurx_pkg::PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    if (verdict) begin
      phase_next = nurx_pkg::PH_DONE;
    end

    // result selection
    res.valid           = 1'b0;
    res.item.url_byte   = 8'd0;
    res.item.has_byte   = 1'b0;
    res.item.final_res  = 1'b0;
    res.item.status     = nurx_pkg::ST_OK;
    res.item.url_length = 8'd0;
    if (verdict) begin
      res.valid           = 1'b1;
      res.item.final_res  = 1'b1;
      res.item.status     = verdict_st;
    end else if (emit_final) begin
      res.valid           = 1'b1;
      res.item.url_byte   = b;
      res.item.has_byte   = 1'b1;
      res.item.final_res  = 1'b1;
      res.item.url_length = url_count_next;
    end else if (item.last_byte && phase_next != nurx_pkg::PH_DONE) begin
      res.valid           = 1'b1;
      res.item.final_res  = 1'b1;
      res.item.status     = nurx_pkg::ST_BAD_LEN;
    end else if (emit) begin
      res.valid           = 1'b1;
      res.item.url_byte   = b;
      res.item.has_byte   = 1'b1;
    end
    res.valid = res.valid && step;

    // saturating byte counter
    byte_index_next = (byte_index < nurx_pkg::IDX_MAX) ? byte_index + 17'd1 : byte_index;

    // last byte returns the parser to its reset state
    if (item.last_byte) begin
      phase_next                 = nurx_pkg::PH_TAG;
      byte_index_next            = 17'd0;
      held_buffer_length_next    = 17'd0;
      message_length_next        = 16'd0;
      message_end_next           = 17'd0;
      record_start_next          = 17'd0;
      record_header_next         = 8'd0;
      record_type_length_next    = 8'd0;
      record_payload_length_next = 8'd0;
      url_bytes_left_next        = 8'd0;
      url_count_next             = 8'd0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= nurx_pkg::PH_TAG;
      byte_index            <= 17'd0;
      held_buffer_length    <= 17'd0;
      message_length        <= 16'd0;
      message_end           <= 17'd0;
      record_start          <= 17'd0;
      record_header         <= 8'd0;
      record_type_length    <= 8'd0;
      record_payload_length <= 8'd0;
      url_bytes_left        <= 8'd0;
      url_count             <= 8'd0;
    end else if (step) begin
      phase                 <= phase_next;
      byte_index            <= byte_index_next;
      held_buffer_length    <= held_buffer_length_next;
      message_length        <= message_length_next;
      message_end           <= message_end_next;
      record_start          <= record_start_next;
      record_header         <= record_header_next;
      record_type_length    <= record_type_length_next;
      record_payload_length <= record_payload_length_next;
      url_bytes_left        <= url_bytes_left_next;
      url_count             <= url_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/nurx_out_stage.sv
// result register of the ndef uri record extractor
// depends on nurx_pkg
`default_nettype none

module nurx_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire nurx_pkg::out_item_t res_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output nurx_pkg::out_item_t      out_data
);

  // result valid: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res_item;
    end
  end

endmodule

`default_nettype wire

### rtl/ndef_uri_record_extractor_top.sv
// top level of the ndef uri record extractor: input register, parse core, result register
// depends on nurx_pkg, nurx_in_stage, nurx_parse_core, nurx_out_stage
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | in_valid / in_ready  | in_data  (in_byte, buffer_length, last_byte)
//   result   | out_valid / out_ready| out_data (url_byte, has_byte, final_res, ...)
//   config   | cfg_we               | cfg_wdata (url_capacity, 9 bits)
//
// one byte per cycle sustained while the result register has room; a byte waits in the input register
// and the parse logic loads its result into the result register when the byte moves on
// bytes causing no result pass through without occupying the result register
// a held result with out_ready low stalls the parse stage; the input side fills one deep
// synchronous reset returns the parser to tag search and url_capacity to 256
`default_nettype none

module ndef_uri_record_extractor_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [8:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire nurx_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output nurx_pkg::out_item_t      out_data
);

  logic                s1_valid;
  nurx_pkg::in_item_t  s1_data;
  logic                advance;
  nurx_pkg::nurx_res_t res;

  // held byte moves when the result register has room
  assign advance = s1_valid && (!out_valid || out_ready);

  nurx_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  nurx_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (s1_data),
    .res       (res)
  );

  nurx_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res.valid),
    .res_item  (res.item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/nurx_port_checker.sv
// port-level checks on the ndef uri record extractor, bound to its top level
// depends on nurx_pkg and ndef_uri_record_extractor_top_macros.svh
`default_nettype none
`include "ndef_uri_record_extractor_top_macros.svh"

module nurx_port_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire nurx_pkg::out_item_t out_data
);

  // a stalled result transaction holds
  `NURX_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // status-only results end the message and carry no byte or length
  `NURX_ASSERT(a_status_final, clk, rst, out_valid && !out_data.has_byte |-> out_data.final_res && out_data.url_byte == 8'd0 && out_data.url_length == 8'd0, "malformed status result")

  // url bytes always carry ok status; only the final one carries a nonzero length
  `NURX_ASSERT(a_url_ok, clk, rst, out_valid && out_data.has_byte |-> out_data.status == nurx_pkg::ST_OK && (out_data.final_res || out_data.url_length == 8'd0) && (!out_data.final_res || out_data.url_length != 8'd0), "malformed url byte result")

  // no result right after reset
  `NURX_ASSERT_ALL(a_reset_quiet, clk, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind ndef_uri_record_extractor_top nurx_port_checker u_port_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
